@@ rtl/scwa_pkg.sv @@
// ----------------------------------------------------------------------------
// scwa_pkg
// shared constants for the scanned channel window averager: register
// indexes, averaging shift and temperature conversion constants
// ----------------------------------------------------------------------------
package scwa_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS_USED   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_CODE_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_CODE_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_CODE_THIRD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MUX_CODE_FOURTH = 3'd4;

    localparam int CHAN_W    = 3;
    localparam int MUX_W     = 4;
    localparam int MUX_REGS  = 4;
    localparam int SLOT_OUT_W = 2;

    // averaging
    localparam int AVG_SHIFT = 5;

    // temperature = (average - 1864) * 25 / 17, truncated toward zero
    localparam int TEMP_W      = 13;
    localparam int TEMP_DIFF_W = 18;
    localparam int PROD_W      = 23;
    localparam int MAG_W       = 21;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int QUO_W       = MAG_W + RECIP_W - RECIP_SHIFT;

    localparam logic signed [TEMP_DIFF_W-1:0] TEMP_OFFSET = 18'sd1864;
    // ceil(2^26 / 17), exact for magnitudes below 2^21
    localparam logic [RECIP_W-1:0] TEMP_RECIP = 22'd3947581;
    localparam logic [QUO_W-1:0] TEMP_POS_LIMIT = 17'd4095;
    localparam logic [QUO_W-1:0] TEMP_NEG_LIMIT = 17'd4096;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd4095;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd4096;

endpackage

@@ rtl/scwa_temp_calc.sv @@
// ----------------------------------------------------------------------------
// scwa_temp_calc
// two-stage temperature conversion: scaled offset difference, then divide
// by 17 through a reciprocal multiply, with saturation to 13 bits signed
// ----------------------------------------------------------------------------
module scwa_temp_calc #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [SAMPLE_BITS-1:0]                avg,
    output logic signed [scwa_pkg::TEMP_W-1:0]    temp
);
    import scwa_pkg::*;

    logic signed [TEMP_DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      prod_abs;
    logic                          neg_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [MAG_W+RECIP_W-1:0]      q_prod;
    logic [QUO_W-1:0]              quo;
    logic signed [TEMP_W-1:0]      temp_next;
    logic signed [TEMP_W-1:0]      temp_reg;

    // times 25 as shift and add
    always_comb
    begin
        diff     = signed'(TEMP_DIFF_W'(avg)) - TEMP_OFFSET;
        prod     = (PROD_W'(diff) <<< 4) + (PROD_W'(diff) <<< 3) + PROD_W'(diff);
        prod_abs = prod[PROD_W-1] ? -prod : prod;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= prod[PROD_W-1];
            mag_reg <= prod_abs[MAG_W-1:0];
        end
    end

    always_comb
    begin
        q_prod = (MAG_W+RECIP_W)'(mag_reg) * (MAG_W+RECIP_W)'(TEMP_RECIP);
        quo    = q_prod[MAG_W+RECIP_W-1:RECIP_SHIFT];
        if (!neg_reg && quo > TEMP_POS_LIMIT)
        begin
            temp_next = TEMP_MAX;
        end
        else if (neg_reg && quo > TEMP_NEG_LIMIT)
        begin
            temp_next = TEMP_MIN;
        end
        else if (neg_reg)
        begin
            temp_next = -signed'(quo[TEMP_W-1:0]);
        end
        else
        begin
            temp_next = signed'(quo[TEMP_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg <= temp_next;
        end
    end

    assign temp = temp_reg;

endmodule

@@ rtl/scanned_channel_window_averager.sv @@
// ----------------------------------------------------------------------------
// scanned_channel_window_averager
// per-slot moving average over a round-robin converter scan, with
// temperature conversion and next multiplexer code
// ----------------------------------------------------------------------------
// With the output free, one sample is taken per clock and the block sustains
// one item every cycle; each result passes the stage 1, 2, 3 and output
// registers. The rate is set by the ring memory, which does one read and one
// write per cycle: the old entry is read and the new sample written at the
// same address in the accept cycle, the running sum is updated from the stage
// 1 registers, and the temperature takes two more stages (scaled difference,
// then a reciprocal multiply for the divide by 17). A stall on the output
// freezes the whole pipeline. The ring needs no clearing pass after reset:
// while a slot's fill count is below the window depth the entry being replaced
// has never been written, so it counts as zero. Configuration writes are taken
// at any time (ready is always high) and should only be issued while idle.
// ----------------------------------------------------------------------------
module scanned_channel_window_averager #(
    parameter int WINDOW_DEPTH = 32,
    parameter int MAX_SLOTS    = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scwa_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [scwa_pkg::MUX_W-1:0]             cfg_data,
    // sample input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [SAMPLE_BITS-1:0]                 sample,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [scwa_pkg::SLOT_OUT_W-1:0]        slot_index,
    output logic [SAMPLE_BITS-1:0]                 sample_taken,
    output logic [SAMPLE_BITS-1:0]                 average,
    output logic                                   average_ready,
    output logic signed [scwa_pkg::TEMP_W-1:0]     temperature,
    output logic [scwa_pkg::MUX_W-1:0]             next_mux_code
);
    import scwa_pkg::*;

    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CMP_W   = SLOT_W + 2;
    localparam int WP_W    = $clog2(WINDOW_DEPTH);
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
    localparam int RING_DEPTH = MAX_SLOTS * WINDOW_DEPTH;
    localparam int ADDR_W  = $clog2(RING_DEPTH);
    localparam logic [SAMPLE_BITS-1:0] SMAX = {SAMPLE_BITS{1'b1}};

    // configuration registers
    logic [CHAN_W-1:0] channels_used_reg;
    logic [MUX_W-1:0]  mux_code_reg [MUX_REGS];

    // per-slot state
    logic [SLOT_W-1:0] scan_slot_reg;
    logic [FILL_W-1:0] fill_reg [MAX_SLOTS];
    logic [WP_W-1:0]   wp_reg   [MAX_SLOTS];
    logic [SUM_W-1:0]  sum_reg  [MAX_SLOTS];

    // sample ring
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] ring_rdata_reg;

    // pipeline control
    logic accept;
    logic en;

    // accept stage
    logic [SLOT_W-1:0] slot0;
    logic [FILL_W-1:0] fill0;
    logic [WP_W-1:0]   wp0;
    logic              old_live0;
    logic [FILL_W-1:0] fill_next;
    logic [WP_W-1:0]   wp_next;
    logic              ready0;
    logic [CMP_W-1:0]  active_cnt;
    logic [CMP_W-1:0]  slot_inc;
    logic [SLOT_W-1:0] scan_slot_next;
    logic [CMP_W-1:0]  next_wide;
    logic [MUX_W-1:0]  mux0;
    logic [ADDR_W-1:0] ring_addr;

    // stage 1: ring data back, running sum update
    logic                   s1_valid_reg;
    logic [SLOT_W-1:0]      s1_slot_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_old_live_reg;
    logic                   s1_ready_reg;
    logic [MUX_W-1:0]       s1_mux_reg;
    logic [SAMPLE_BITS-1:0] s1_old;
    logic [SUM_W-1:0]       sum_next;
    logic [SUM_W-1:0]       avg_shift;
    logic [SAMPLE_BITS-1:0] avg1;

    // stage 2 and 3 payload alongside the temperature pipeline
    logic                   s2_valid_reg;
    logic [SLOT_W-1:0]      s2_slot_reg;
    logic [SAMPLE_BITS-1:0] s2_sample_reg;
    logic [SAMPLE_BITS-1:0] s2_avg_reg;
    logic                   s2_ready_reg;
    logic [MUX_W-1:0]       s2_mux_reg;

    logic                   s3_valid_reg;
    logic [SLOT_W-1:0]      s3_slot_reg;
    logic [SAMPLE_BITS-1:0] s3_sample_reg;
    logic [SAMPLE_BITS-1:0] s3_avg_reg;
    logic                   s3_ready_reg;
    logic [MUX_W-1:0]       s3_mux_reg;

    // output register
    logic                   out_valid_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic [SAMPLE_BITS-1:0] out_avg_reg;
    logic                   out_ready_reg;
    logic [MUX_W-1:0]       out_mux_reg;

    // whole pipeline holds while a finished result is stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign accept   = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_used_reg <= 3'd3;
            mux_code_reg[0]   <= 4'd0;
            mux_code_reg[1]   <= 4'd1;
            mux_code_reg[2]   <= 4'd2;
            mux_code_reg[3]   <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHANNELS_USED:   channels_used_reg <= cfg_data[CHAN_W-1:0];
                CFG_MUX_CODE_FIRST:  mux_code_reg[0]   <= cfg_data;
                CFG_MUX_CODE_SECOND: mux_code_reg[1]   <= cfg_data;
                CFG_MUX_CODE_THIRD:  mux_code_reg[2]   <= cfg_data;
                CFG_MUX_CODE_FOURTH: mux_code_reg[3]   <= cfg_data;
                default:             ; // unused indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // accept stage: slot pointers, fill count, scan sequencing
    // ------------------------------------------------------------------
    always_comb
    begin
        slot0     = scan_slot_reg;
        fill0     = fill_reg[slot0];
        wp0       = wp_reg[slot0];
        // a full ring means the entry being replaced holds a real sample
        old_live0 = (fill0 == FILL_W'(WINDOW_DEPTH));
        fill_next = old_live0 ? fill0 : fill0 + 1'b1;
        ready0    = (fill_next == FILL_W'(WINDOW_DEPTH));
        wp_next   = (wp0 == WP_W'(WINDOW_DEPTH - 1)) ? '0 : wp0 + 1'b1;

        // channel count clamped to one through the slot count
        if (channels_used_reg == '0)
        begin
            active_cnt = CMP_W'(1);
        end
        else if (CMP_W'(channels_used_reg) > CMP_W'(MAX_SLOTS))
        begin
            active_cnt = CMP_W'(MAX_SLOTS);
        end
        else
        begin
            active_cnt = CMP_W'(channels_used_reg);
        end

        // a slot left beyond a lowered count still wraps to slot 0
        slot_inc = CMP_W'(slot0) + 1'b1;
        scan_slot_next = (slot_inc >= active_cnt) ? '0 : slot_inc[SLOT_W-1:0];

        // slots past the fourth have no mux register
        next_wide = CMP_W'(scan_slot_next);
        if (next_wide < CMP_W'(MUX_REGS))
        begin
            mux0 = mux_code_reg[next_wide[1:0]];
        end
        else
        begin
            mux0 = '0;
        end

        ring_addr = ADDR_W'(slot0 * WINDOW_DEPTH + wp0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_slot_reg <= '0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                fill_reg[i] <= '0;
                wp_reg[i]   <= '0;
            end
        end
        else if (accept)
        begin
            scan_slot_reg   <= scan_slot_next;
            fill_reg[slot0] <= fill_next;
            wp_reg[slot0]   <= wp_next;
        end
    end

    // ring memory: read-before-write at the same address in the same cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[ring_addr] <= sample;
        end
        if (en)
        begin
            ring_rdata_reg <= ring_mem[ring_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_slot_reg     <= slot0;
            s1_sample_reg   <= sample;
            s1_old_live_reg <= old_live0;
            s1_ready_reg    <= ready0;
            s1_mux_reg      <= mux0;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: running sum and window average
    // ------------------------------------------------------------------
    always_comb
    begin
        // an entry never written counts as zero
        s1_old    = s1_old_live_reg ? ring_rdata_reg : '0;
        sum_next  = sum_reg[s1_slot_reg] - SUM_W'(s1_old) + SUM_W'(s1_sample_reg);
        avg_shift = sum_next >> AVG_SHIFT;
        if (!s1_ready_reg)
        begin
            avg1 = '0;
        end
        else if (avg_shift > SUM_W'(SMAX))
        begin
            avg1 = SMAX;
        end
        else
        begin
            avg1 = avg_shift[SAMPLE_BITS-1:0];
        end
    end

    // sum is only read and written here, so back-to-back items of one slot
    // see each other's update without forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else if (en && s1_valid_reg)
        begin
            sum_reg[s1_slot_reg] <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // stages 2 and 3, output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_slot_reg    <= s1_slot_reg;
            s2_sample_reg  <= s1_sample_reg;
            s2_avg_reg     <= avg1;
            s2_ready_reg   <= s1_ready_reg;
            s2_mux_reg     <= s1_mux_reg;

            s3_slot_reg    <= s2_slot_reg;
            s3_sample_reg  <= s2_sample_reg;
            s3_avg_reg     <= s2_avg_reg;
            s3_ready_reg   <= s2_ready_reg;
            s3_mux_reg     <= s2_mux_reg;

            out_slot_reg   <= s3_slot_reg;
            out_sample_reg <= s3_sample_reg;
            out_avg_reg    <= s3_avg_reg;
            out_ready_reg  <= s3_ready_reg;
            out_mux_reg    <= s3_mux_reg;
        end
    end

    // temperature lands in its own output register in step with the rest
    scwa_temp_calc #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_temp_calc (
        .clk  (clk),
        .en   (en),
        .avg  (s2_avg_reg),
        .temp (temperature)
    );

    assign out_valid     = out_valid_reg;
    assign slot_index    = SLOT_OUT_W'(out_slot_reg);
    assign sample_taken  = out_sample_reg;
    assign average       = out_avg_reg;
    assign average_ready = out_ready_reg;
    assign next_mux_code = out_mux_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted sample did not enter stage 1");

    a_avg_zero_unfilled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !average_ready) |-> (average == '0))
        else $error("average nonzero before window is full");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg[scan_slot_reg] <= FILL_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    a_wp_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[scan_slot_reg] != FILL_W'(WINDOW_DEPTH)) |->
        (FILL_W'(wp_reg[scan_slot_reg]) == fill_reg[scan_slot_reg]))
        else $error("write pointer out of step with fill count");

endmodule

@@ tb/scanned_channel_window_averager_tb.sv @@
// ----------------------------------------------------------------------------
// scanned_channel_window_averager_tb
// self-checking bench for the scanned channel window averager: a small
// scoreboard predicts every result from the accepted samples and the register
// writes, random idling on both channels exercises the handshakes
// ----------------------------------------------------------------------------
module scanned_channel_window_averager_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scwa_pkg::*;

    localparam int SAMPLE_W     = 12;
    localparam int WINDOW       = 32;
    localparam int SLOTS        = 4;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    // temperature scaling, (average - offset) * num / den
    localparam int TEMP_NUM     = 25;
    localparam int TEMP_DEN     = 17;
    localparam int TEMP_HI      = 4095;
    localparam int TEMP_LO      = -4096;
    // sizes the extra drain wait in settle
    localparam int LATENCY      = 3;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 192;
    localparam int MAX_GAP      = 40;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // register indexes past the last mux register, ignored by the block
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNMAPPED = 3'd5;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        PAT_UNIFORM,
        PAT_FULL_SCALE,
        PAT_ZERO,
        PAT_MID_SCALE,
        PAT_RAILS
    } sample_pattern_t;

    typedef struct {
        logic [SLOT_OUT_W-1:0]   slot;
        logic [SAMPLE_W-1:0]     taken;
        logic [SAMPLE_W-1:0]     average;
        logic                    ready;
        logic signed [TEMP_W-1:0] temperature;
        logic [MUX_W-1:0]        next_mux;
    } scan_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: per-slot rings and running sums, expected results in order
    // ------------------------------------------------------------------------
    class window_average_tracker;
        int unsigned ring [SLOTS][WINDOW];
        int unsigned fill [SLOTS];
        int unsigned wr_ptr [SLOTS];
        int unsigned window_sum [SLOTS];
        int unsigned scan_slot;
        int unsigned channel_setting;
        logic [MUX_W-1:0] mux_code [MUX_REGS];
        scan_result_t expected_averages [$];
        int unsigned mismatches;

        function new();
            for (int s = 0; s < SLOTS; s++)
            begin
                for (int w = 0; w < WINDOW; w++)
                    ring[s][w] = 0;
                fill[s]       = 0;
                wr_ptr[s]     = 0;
                window_sum[s] = 0;
            end
            scan_slot       = 0;
            channel_setting = 3;
            mux_code[0]     = 4'd0;
            mux_code[1]     = 4'd1;
            mux_code[2]     = 4'd2;
            mux_code[3]     = 4'd8;
            mismatches      = 0;
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [MUX_W-1:0] data);
            case (idx) inside
                CFG_CHANNELS_USED:
                    channel_setting = data[CHAN_W-1:0];
                CFG_MUX_CODE_FIRST, CFG_MUX_CODE_SECOND, CFG_MUX_CODE_THIRD,
                CFG_MUX_CODE_FOURTH:
                    mux_code[2'(idx - CFG_MUX_CODE_FIRST)] = data;
                default:
                    ;
            endcase
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] s);
            int unsigned slot;
            int unsigned scan_len;
            int unsigned nxt;
            int avg;
            int temp;
            scan_result_t r;
            slot = scan_slot % SLOTS;
            window_sum[slot] = window_sum[slot] - ring[slot][wr_ptr[slot]] + s;
            ring[slot][wr_ptr[slot]] = s;
            wr_ptr[slot] = (wr_ptr[slot] + 1) % WINDOW;
            if (fill[slot] < WINDOW)
                fill[slot]++;
            r.ready = (fill[slot] == WINDOW);
            avg = 0;
            if (r.ready)
            begin
                avg = window_sum[slot] >> AVG_SHIFT;
                if (avg > SAMPLE_MAX)
                    avg = SAMPLE_MAX;
            end
            temp = ((avg - int'(TEMP_OFFSET)) * TEMP_NUM) / TEMP_DEN;
            if (temp > TEMP_HI)
                temp = TEMP_HI;
            if (temp < TEMP_LO)
                temp = TEMP_LO;
            // zero acts as one slot, anything above the slot count as all slots
            scan_len = (channel_setting == 0) ? 1 :
                       (channel_setting > SLOTS) ? SLOTS : channel_setting;
            nxt = slot + 1;
            if (nxt >= scan_len)
                nxt = 0;
            scan_slot = nxt;
            r.slot        = slot[SLOT_OUT_W-1:0];
            r.taken       = s;
            r.average     = avg[SAMPLE_W-1:0];
            r.temperature = TEMP_W'(temp);
            r.next_mux    = (nxt < MUX_REGS) ? mux_code[nxt] : '0;
            expected_averages.push_back(r);
        endfunction

        function void report(string field, int exp_v, int act_v);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
            mismatches++;
        endfunction

        function void match_result(scan_result_t got);
            scan_result_t e;
            if (expected_averages.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got slot %0d sample %0d",
                         $time, got.slot, got.taken);
                mismatches++;
                return;
            end
            e = expected_averages.pop_front();
            if (got.slot !== e.slot)
                report("slot_index", e.slot, got.slot);
            if (got.taken !== e.taken)
                report("sample_taken", e.taken, got.taken);
            if (got.average !== e.average)
                report("average", e.average, got.average);
            if (got.ready !== e.ready)
                report("average_ready", e.ready, got.ready);
            if (got.temperature !== e.temperature)
                report("temperature", e.temperature, got.temperature);
            if (got.next_mux !== e.next_mux)
                report("next_mux_code", e.next_mux, got.next_mux);
        endfunction

        function int unsigned pending();
            return expected_averages.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [MUX_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic [SAMPLE_W-1:0]        sample;
    logic                       out_valid;
    logic                       out_stall;
    logic [SLOT_OUT_W-1:0]      slot_index;
    logic [SAMPLE_W-1:0]        sample_taken;
    logic [SAMPLE_W-1:0]        average;
    logic                       average_ready;
    logic signed [TEMP_W-1:0]   temperature;
    logic [MUX_W-1:0]           next_mux_code;

    // percent of cycles each side spends idle or stalled
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;

    // current random sample pattern and how many samples it still lasts
    sample_pattern_t pattern = PAT_UNIFORM;
    int unsigned     pattern_left = 0;

    window_average_tracker results;

    scanned_channel_window_averager #(
        .WINDOW_DEPTH (WINDOW),
        .MAX_SLOTS    (SLOTS),
        .SAMPLE_BITS  (SAMPLE_W)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot_index    (slot_index),
        .sample_taken  (sample_taken),
        .average       (average),
        .average_ready (average_ready),
        .temperature   (temperature),
        .next_mux_code (next_mux_code)
    );

    // 10 ns clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: every transfer is seen at the rising edge
    always @(posedge clk)
    begin
        scan_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                results.note_config(cfg_index, cfg_data);
            // note the sample before checking so a result in the same cycle still lines up
            if (in_valid && !in_stall)
                results.take_sample(sample);
            if (out_valid && !out_stall)
            begin
                got.slot        = slot_index;
                got.taken       = sample_taken;
                got.average     = average;
                got.ready       = average_ready;
                got.temperature = temperature;
                got.next_mux    = next_mux_code;
                results.match_result(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------

    // one sample transfer, with an optional idle gap in front of it
    task automatic push_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [MUX_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, let every expected result arrive, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results.pending() != 0)
            @(negedge clk);
        repeat (2 * LATENCY) @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
            default:       begin send_idle_pct = 19; stall_pct = 19; end
        endcase
    endtask

    // samples come in runs of one pattern, 32 to 160 samples long
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned draw;
        if (pattern_left == 0)
        begin
            draw = $urandom_range(7);
            // uniform samples get the extra weight
            pattern = (draw > PAT_RAILS) ? PAT_UNIFORM : sample_pattern_t'(draw);
            pattern_left = $urandom_range(160, 32);
        end
        pattern_left--;
        case (pattern)
            PAT_FULL_SCALE: return SAMPLE_W'(SAMPLE_MAX);
            PAT_ZERO:       return '0;
            // averages around the temperature zero point
            PAT_MID_SCALE:  return SAMPLE_W'($urandom_range(1890, 1840));
            PAT_RAILS:      return $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            default:        return SAMPLE_W'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int chan_plan [PHASES];
        results   = new();
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        // one and the full scan among them, wider codes wrap in the 3-bit field
        chan_plan = '{4, 1, 2, 7, 0, 3, 12, 13};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, three-slot scan, rails and bit patterns
        set_idling(IDLE_NONE);
        push_sample('0);
        push_sample(SAMPLE_W'(SAMPLE_MAX));
        push_sample(12'hAAA);
        push_sample(12'h555);
        push_sample(12'h001);
        settle();

        // scan sits at slot 2, one channel puts it beyond the scan
        write_reg(CFG_CHANNELS_USED, 4'd1);
        write_reg(CFG_MUX_CODE_FIRST, 4'd15);
        push_sample(12'h800);
        push_sample(12'h7FF);
        push_sample(12'hFFE);
        settle();

        // zero channels acts as a single slot
        write_reg(CFG_CHANNELS_USED, 4'd0);
        write_reg(CFG_MUX_CODE_FIRST, 4'd0);
        push_sample(12'h0F0);
        push_sample(12'hF0F);
        settle();

        // count above the slot number, full four-slot scan, extreme mux codes
        write_reg(CFG_CHANNELS_USED, 4'd15);
        write_reg(CFG_MUX_CODE_SECOND, 4'd15);
        write_reg(CFG_MUX_CODE_THIRD, 4'd0);
        write_reg(CFG_MUX_CODE_FOURTH, 4'd15);
        push_sample(12'h123);
        push_sample(12'hEDC);
        push_sample(SAMPLE_W'(SAMPLE_MAX));
        push_sample('0);
        push_sample(12'h748);
        settle();

        // unmapped indexes leave every setting alone
        write_reg(CFG_FIRST_UNMAPPED, 4'd15);
        write_reg(CFG_FIRST_UNMAPPED + 3'd2, 4'd10);
        write_reg(CFG_CHANNELS_USED, 4'd4);
        push_sample(12'h3C3);
        push_sample(12'hC3C);
        push_sample(12'h999);
        push_sample(12'h666);
        settle();

        // random phases, each with its own settings and idling
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_CHANNELS_USED, MUX_W'(chan_plan[p]));
            for (int m = 0; m < MUX_REGS; m++)
                write_reg(CFG_INDEX_W'(CFG_MUX_CODE_FIRST + m),
                          (p == 0) ? 4'd15 : (p == 1) ? 4'd0 : MUX_W'($urandom_range(15)));
            write_reg(CFG_INDEX_W'(CFG_FIRST_UNMAPPED + (p % 3)),
                      MUX_W'($urandom_range(15)));
            set_idling(idle_mode_t'(p % 4));
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_sample(pick_sample());
            settle();
        end

        if (results.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
